>>> rtl/rtc_cal_pkg.sv
// ----------------------------------------------------------------------------
// RTC calendar package
// Shared types, reset values and calendar helpers for the RTC calendar block.
// ----------------------------------------------------------------------------
package rtc_cal_pkg;

  // Width of the internal year counter; the year wraps modulo 2**YearBits.
  localparam int unsigned YearBits = 16;
  localparam int unsigned YearPortBits = 16;

  localparam logic [0:0] CmdTick = 1'b0;
  localparam logic [0:0] CmdLoad = 1'b1;

  localparam logic [5:0] SecondMax = 6'd59;
  localparam logic [5:0] MinuteMax = 6'd59;
  localparam logic [4:0] HourMax = 5'd23;
  localparam logic [2:0] WeekdayMax = 3'd7;
  localparam logic [3:0] MonthMax = 4'd12;

  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthNov = 4'd11;

  localparam logic [5:0] SecondReset = 6'd50;
  localparam logic [5:0] MinuteReset = 6'd0;
  localparam logic [4:0] HourReset = 5'd15;
  localparam logic [2:0] WeekdayReset = 3'd4;
  localparam logic [4:0] DateReset = 5'd1;
  localparam logic [3:0] MonthReset = 4'd1;
  localparam logic [YearBits-1:0] YearReset = '0;

  typedef struct packed {
    logic [0:0]  cmd;
    logic [5:0]  load_second;
    logic [5:0]  load_minute;
    logic [4:0]  load_hour;
    logic [2:0]  load_weekday;
    logic [4:0]  load_date;
    logic [3:0]  load_month;
    logic [15:0] load_year;
  } rtc_in_t;

  typedef struct packed {
    logic [5:0]  sec_out;
    logic [5:0]  min_out;
    logic [4:0]  hour_out;
    logic [2:0]  weekday_out;
    logic [4:0]  date_out;
    logic [3:0]  month_out;
    logic [15:0] year_out;
    logic        minute_rollover;
  } rtc_out_t;

  typedef struct packed {
    logic [5:0]          second;
    logic [5:0]          minute;
    logic [4:0]          hour;
    logic [2:0]          weekday;
    logic [4:0]          date;
    logic [3:0]          month;
    logic [YearBits-1:0] year;
  } rtc_time_t;

  // Multiplicative inverse of an odd value modulo 2**YearBits (Newton steps).
  function automatic logic [YearBits-1:0] odd_inverse(input logic [YearBits-1:0] a);
    logic [YearBits-1:0] x;
    x = a;
    for (int i = 0; i < 5; i++) begin
      x = x * (YearBits'(2) - a * x);
    end
    return x;
  endfunction

  // A value is a multiple of 25 exactly when its product with the inverse
  // of 25 lands at or below the largest multiple's quotient.
  localparam logic [YearBits-1:0] Inv25 = odd_inverse(YearBits'(25));
  localparam logic [YearBits-1:0] Div25Max = YearBits'(((64'd1 << YearBits) - 1) / 25);

endpackage

>>> rtl/rtc_cal_in_stage.sv
// ----------------------------------------------------------------------------
// RTC calendar input stage
// Registers one command item and holds it until the update stage takes it.
// ----------------------------------------------------------------------------
module rtc_cal_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rtc_cal_pkg::rtc_in_t in_data_i,
  input  logic                ready_i,
  output logic                valid_o,
  output rtc_cal_pkg::rtc_in_t data_o
);

  logic                 valid_q;
  rtc_cal_pkg::rtc_in_t data_q;

  assign in_stall_o = valid_q && !ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_i || !valid_q) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/rtc_cal_step.sv
// ----------------------------------------------------------------------------
// RTC calendar step logic
// Computes the counters after one tick or load, and the rollover flag.
// ----------------------------------------------------------------------------
module rtc_cal_step (
  input  rtc_cal_pkg::rtc_time_t cur_i,
  input  rtc_cal_pkg::rtc_in_t   item_i,
  output rtc_cal_pkg::rtc_time_t next_o,
  output logic                   rollover_o
);

  logic [rtc_cal_pkg::YearBits-1:0] year_prod;
  logic                             div25;
  logic                             leap;
  logic [4:0]                       last_day;

  // Leap: divisible by 4, and a century (multiple of 4 and 25) only when
  // also divisible by 16, i.e. by 400.
  assign year_prod = cur_i.year * rtc_cal_pkg::Inv25;
  assign div25     = (year_prod <= rtc_cal_pkg::Div25Max);
  assign leap      = (cur_i.year[1:0] == 2'b00) && (!div25 || (cur_i.year[3:0] == 4'b0000));

  always_comb begin
    if ((cur_i.month == rtc_cal_pkg::MonthApr) || (cur_i.month == rtc_cal_pkg::MonthJun) ||
        (cur_i.month == rtc_cal_pkg::MonthSep) || (cur_i.month == rtc_cal_pkg::MonthNov)) begin
      last_day = 5'd30;
    end else if (cur_i.month == rtc_cal_pkg::MonthFeb) begin
      last_day = leap ? 5'd29 : 5'd28;
    end else begin
      last_day = 5'd31;
    end
  end

  always_comb begin
    next_o     = cur_i;
    rollover_o = 1'b0;
    if (item_i.cmd == rtc_cal_pkg::CmdLoad) begin
      next_o.second  = item_i.load_second;
      next_o.minute  = item_i.load_minute;
      next_o.hour    = item_i.load_hour;
      next_o.weekday = item_i.load_weekday;
      next_o.date    = item_i.load_date;
      next_o.month   = item_i.load_month;
      next_o.year    = rtc_cal_pkg::YearBits'(item_i.load_year);
    end else if (cur_i.second >= rtc_cal_pkg::SecondMax) begin
      next_o.second = '0;
      rollover_o    = 1'b1;
      if (cur_i.minute >= rtc_cal_pkg::MinuteMax) begin
        next_o.minute = '0;
        if (cur_i.hour >= rtc_cal_pkg::HourMax) begin
          next_o.hour    = '0;
          next_o.weekday = (cur_i.weekday >= rtc_cal_pkg::WeekdayMax) ? 3'd1
                                                                      : cur_i.weekday + 3'd1;
          if (cur_i.date >= last_day) begin
            next_o.date = 5'd1;
            if (cur_i.month >= rtc_cal_pkg::MonthMax) begin
              next_o.month = 4'd1;
              next_o.year  = cur_i.year + rtc_cal_pkg::YearBits'(1);
            end else begin
              next_o.month = cur_i.month + 4'd1;
            end
          end else begin
            next_o.date = cur_i.date + 5'd1;
          end
        end else begin
          next_o.hour = cur_i.hour + 5'd1;
        end
      end else begin
        next_o.minute = cur_i.minute + 6'd1;
      end
    end else begin
      next_o.second = cur_i.second + 6'd1;
    end
  end

endmodule

>>> rtl/rtc_calendar_counter.sv
// ----------------------------------------------------------------------------
// RTC calendar counter
// Seconds-to-year real-time clock calendar with a load command.
// ----------------------------------------------------------------------------
// Each transfer on the input is either a one-second tick or a load of every
// time field. Every input transfer yields exactly one output transfer showing
// the time after that command, with minute_rollover set when a tick wrapped
// the seconds to zero. The block takes one command per clock cycle while the
// output is not stalled: a command is held in the input register, then the
// calendar counters and the output register update together from it, and the
// result is held on the output until it transfers. After reset the clock
// reads 15:00:50, weekday 4, day 1 of month 1, year 0.
module rtc_calendar_counter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rtc_cal_pkg::rtc_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rtc_cal_pkg::rtc_out_t out_data_o
);

  logic                   s1_valid;
  rtc_cal_pkg::rtc_in_t   s1_item;
  logic                   s2_ready;
  rtc_cal_pkg::rtc_time_t time_q;
  rtc_cal_pkg::rtc_time_t time_d;
  logic                   rollover;
  logic                   out_valid_q;
  rtc_cal_pkg::rtc_out_t  out_data_q;

  assign s2_ready = !out_valid_q || !out_stall_i;

  rtc_cal_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .ready_i    (s2_ready),
    .valid_o    (s1_valid),
    .data_o     (s1_item)
  );

  rtc_cal_step u_step (
    .cur_i      (time_q),
    .item_i     (s1_item),
    .next_o     (time_d),
    .rollover_o (rollover)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q.second  <= rtc_cal_pkg::SecondReset;
      time_q.minute  <= rtc_cal_pkg::MinuteReset;
      time_q.hour    <= rtc_cal_pkg::HourReset;
      time_q.weekday <= rtc_cal_pkg::WeekdayReset;
      time_q.date    <= rtc_cal_pkg::DateReset;
      time_q.month   <= rtc_cal_pkg::MonthReset;
      time_q.year    <= rtc_cal_pkg::YearReset;
      out_valid_q    <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid;
      if (s1_valid) begin
        time_q <= time_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid) begin
      out_data_q.sec_out         <= time_d.second;
      out_data_q.min_out         <= time_d.minute;
      out_data_q.hour_out        <= time_d.hour;
      out_data_q.weekday_out     <= time_d.weekday;
      out_data_q.date_out        <= time_d.date;
      out_data_q.month_out       <= time_d.month;
      out_data_q.year_out        <= rtc_cal_pkg::YearPortBits'(time_d.year);
      out_data_q.minute_rollover <= rollover;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
